### design/arcio_pkg.sv
// Shared types and constants for the arcade I/O and sound latch unit.
// Holds the access codes, the bus address map and the request/result structs.
// No dependencies.
`timescale 1ns / 1ps

package arcio_pkg;

  // Field widths
  localparam int unsigned OpW      = 3;
  localparam int unsigned AddrW    = 24;
  localparam int unsigned DataW    = 16;
  localparam int unsigned PadIdxW  = 3;
  localparam int unsigned ScrollW  = 17;
  localparam int unsigned NumPads  = 6;
  localparam int unsigned InDataW  = 48;   // 44 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 104;  // 98 bits of fields, padded to bytes

  // Access kinds
  typedef enum logic [OpW-1:0] {
    OpMainWrite  = 3'd0,
    OpMainRead   = 3'd1,
    OpMainByteRd = 3'd2,
    OpSoundWrite = 3'd3,
    OpSoundRead  = 3'd4,
    OpPadLoad    = 3'd5
  } op_e;

  // Main bus write map
  localparam logic [AddrW-1:0] AddrEeprom    = 24'h200000;
  localparam logic [AddrW-1:0] AddrLatch     = 24'h280000;
  localparam logic [AddrW-1:0] AddrBgBank    = 24'h780004;
  localparam logic [AddrW-1:0] AddrFgBank    = 24'h780006;
  localparam logic [AddrW-1:0] AddrBgScrollX = 24'h7a0000;
  localparam logic [AddrW-1:0] AddrBgScrollY = 24'h7a0002;
  localparam logic [AddrW-1:0] AddrFgScrollX = 24'h7a0004;
  localparam logic [AddrW-1:0] AddrFgScrollY = 24'h7a0006;
  localparam logic [AddrW-1:0] AddrLineScrl  = 24'h7a0008;

  // Main bus read map
  localparam logic [AddrW-1:0] AddrPad0      = 24'h180000;
  localparam logic [AddrW-1:0] AddrPad1      = 24'h180002;
  localparam logic [AddrW-1:0] AddrPad2      = 24'h180004;
  localparam logic [AddrW-1:0] AddrPad3      = 24'h180006;
  localparam logic [AddrW-1:0] AddrStatus    = 24'h180008;
  localparam logic [AddrW-1:0] AddrPad5      = 24'h18000a;

  // Sound ports
  localparam logic [7:0] PortBank  = 8'h00;
  localparam logic [7:0] PortLatch = 8'h04;

  // Status word pieces
  localparam logic [DataW-1:0] StatusPadMask = 16'hff2f;
  localparam logic [DataW-1:0] ByteReadValue = 16'h00ff;
  localparam logic [DataW-1:0] PadIdle       = 16'hffff;

  // One bus access
  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [AddrW-1:0]   address;
    logic [DataW-1:0]   data;
    logic               eeprom_bit_in;
    logic [PadIdxW-1:0] pad_index;
  } req_t;

  // One result: read data plus current control levels
  typedef struct packed {
    logic [DataW-1:0]   read_data;
    logic [2:0]         eeprom_lines;
    logic               sound_nmi;
    logic [3:0]         bg_palette_bank;
    logic [3:0]         fg_palette_bank;
    logic [ScrollW-1:0] bg_scroll_x;
    logic [DataW-1:0]   bg_scroll_y;
    logic [ScrollW-1:0] fg_scroll_x;
    logic [ScrollW-1:0] fg_scroll_y;
    logic               line_scroll_on;
    logic [1:0]         sound_rom_bank;
  } res_t;

endpackage

### design/arcio_in_stage.sv
// Input register of the arcade I/O unit: captures one request per cycle when load_i accepts it.
// Depends on arcio_pkg for req_t.
`timescale 1ns / 1ps

module arcio_in_stage
  import arcio_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,     // request accepted this cycle
  input  logic drain_i,    // held request moves on this cycle
  input  req_t req_i,
  output logic valid_o,
  output req_t req_o
);

  logic valid_q, valid_d;
  req_t req_q;

  // Track occupancy: fill on load, empty when drained without refill
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (drain_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload until the next accepted request
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

### design/arcio_core.sv
// Bus decode and control registers of the arcade I/O unit.
// Updates state for one request and forms its result; depends on arcio_pkg.
`timescale 1ns / 1ps

module arcio_core
  import arcio_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic fire_i,     // request in the input register is processed
  input  req_t req_i,
  output res_t res_o
);

  logic                dip_q, dip_d;
  logic [2:0]          eeprom_q, eeprom_d;
  logic [7:0]          latch_q, latch_d;
  logic                pending_q, pending_d;
  logic [3:0]          bg_bank_q, bg_bank_d;
  logic [3:0]          fg_bank_q, fg_bank_d;
  logic [ScrollW-1:0]  bg_x_q, bg_x_d;
  logic [DataW-1:0]    bg_y_q, bg_y_d;
  logic [ScrollW-1:0]  fg_x_q, fg_x_d;
  logic [ScrollW-1:0]  fg_y_q, fg_y_d;
  logic                line_q, line_d;
  logic [1:0]          bank_q, bank_d;
  logic [DataW-1:0]    pad_q [NumPads];
  logic [DataW-1:0]    pad_d [NumPads];

  logic [7:0]          port;
  logic [DataW-1:0]    status;
  logic [DataW-1:0]    rd;
  logic                nmi;

  assign port = req_i.address[7:0];

  // Status word: pad 4 with switch, EEPROM bit and inverted pending merged in
  assign status = (pad_q[4] & StatusPadMask)
                | {11'd0, dip_q, 4'd0}
                | {9'd0, req_i.eeprom_bit_in, 6'd0}
                | {8'd0, ~pending_q, 7'd0};

  // Decode the access: next state and read data
  always_comb begin
    eeprom_d  = eeprom_q;
    latch_d   = latch_q;
    pending_d = pending_q;
    bg_bank_d = bg_bank_q;
    fg_bank_d = fg_bank_q;
    bg_x_d    = bg_x_q;
    bg_y_d    = bg_y_q;
    fg_x_d    = fg_x_q;
    fg_y_d    = fg_y_q;
    line_d    = line_q;
    bank_d    = bank_q;
    pad_d     = pad_q;
    rd        = '0;
    nmi       = 1'b0;
    dip_d     = cfg_we_i ? cfg_wdata_i : dip_q;

    if (fire_i) begin
      unique case (req_i.op)
        OpMainWrite: begin
          unique case (req_i.address)
            AddrEeprom:    eeprom_d  = req_i.data[13:11];
            AddrLatch: begin
              latch_d   = req_i.data[7:0];
              pending_d = 1'b1;
              nmi       = 1'b1;
            end
            AddrBgBank:    bg_bank_d = req_i.data[15:12];
            AddrFgBank:    fg_bank_d = req_i.data[15:12];
            AddrBgScrollX: bg_x_d    = {1'b0, req_i.data} + ScrollW'(1);
            AddrBgScrollY: bg_y_d    = req_i.data;
            AddrFgScrollX: fg_x_d    = {1'b0, req_i.data} - ScrollW'(3);
            AddrFgScrollY: fg_y_d    = {1'b0, req_i.data} + ScrollW'(1);
            AddrLineScrl:  line_d    = ~req_i.data[9];
            default: ;
          endcase
        end
        OpMainRead: begin
          unique case (req_i.address)
            AddrPad0:   rd = pad_q[0];
            AddrPad1:   rd = pad_q[1];
            AddrPad2:   rd = pad_q[2];
            AddrPad3:   rd = pad_q[3];
            AddrPad5:   rd = pad_q[5];
            AddrStatus: rd = status;
            default:    rd = '0;
          endcase
        end
        OpMainByteRd: rd = (req_i.address == AddrStatus) ? ByteReadValue : '0;
        OpSoundWrite: begin
          if (port == PortBank) begin
            bank_d = req_i.data[1:0];
          end else if (port == PortLatch) begin
            pending_d = 1'b0;
          end
        end
        OpSoundRead: rd = (port == PortLatch) ? {8'd0, latch_q} : '0;
        OpPadLoad: begin
          for (int i = 0; i < NumPads; i++) begin
            if (req_i.pad_index == PadIdxW'(i)) begin
              pad_d[i] = req_i.data;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dip_q     <= 1'b1;
      eeprom_q  <= '0;
      latch_q   <= '0;
      pending_q <= 1'b0;
      bg_bank_q <= '0;
      fg_bank_q <= '0;
      bg_x_q    <= '0;
      bg_y_q    <= '0;
      fg_x_q    <= '0;
      fg_y_q    <= '0;
      line_q    <= 1'b0;
      bank_q    <= '0;
      for (int i = 0; i < NumPads; i++) begin
        pad_q[i] <= PadIdle;
      end
    end else begin
      dip_q     <= dip_d;
      eeprom_q  <= eeprom_d;
      latch_q   <= latch_d;
      pending_q <= pending_d;
      bg_bank_q <= bg_bank_d;
      fg_bank_q <= fg_bank_d;
      bg_x_q    <= bg_x_d;
      bg_y_q    <= bg_y_d;
      fg_x_q    <= fg_x_d;
      fg_y_q    <= fg_y_d;
      line_q    <= line_d;
      bank_q    <= bank_d;
      pad_q     <= pad_d;
    end
  end

  // Result shows the levels after this access
  always_comb begin
    res_o.read_data       = rd;
    res_o.eeprom_lines    = eeprom_d;
    res_o.sound_nmi       = nmi;
    res_o.bg_palette_bank = bg_bank_d;
    res_o.fg_palette_bank = fg_bank_d;
    res_o.bg_scroll_x     = bg_x_d;
    res_o.bg_scroll_y     = bg_y_d;
    res_o.fg_scroll_x     = fg_x_d;
    res_o.fg_scroll_y     = fg_y_d;
    res_o.line_scroll_on  = line_d;
    res_o.sound_rom_bank  = bank_d;
  end

endmodule

### design/arcio_out_stage.sv
// Result register of the arcade I/O unit: holds one result until taken.
// Depends on arcio_pkg for res_t.
`timescale 1ns / 1ps

module arcio_out_stage
  import arcio_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,     // new result arrives
  input  logic ready_i,    // downstream takes the held result
  input  res_t res_i,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // Fill on load, drop once taken
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### design/arcade_io_and_sound_latch_unit.sv
// Top level of the arcade I/O and sound latch unit.
// Instantiates arcio_in_stage, arcio_core and arcio_out_stage; uses arcio_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   Each bus access (main CPU read/write, sound CPU port access or pad load)
//   enters as one request on the s_axis channel: tuser carries the access
//   kind, tdata the address, write data, EEPROM data-out level and pad index.
//   Every request yields exactly one result on m_axis: read data plus the
//   current level of every latched control output (EEPROM lines, NMI pulse,
//   palette banks, scroll values, line-scroll enable, sound ROM bank).
//   The 3P/4P switch level is written through cfg_we_i / cfg_wdata_i.
// Timing:
//   A request is registered in the input register, decoded while the
//   control registers update, and its result is registered in the result
//   register, which drives m_axis_tvalid_o. One request per cycle is
//   sustained while the receiver keeps m_axis_tready_i high; the decode is
//   combinational.
// Reset and stall:
//   Reset clears all control registers, sets the pads to idle (all ones)
//   and the switch to one. When the receiver stalls, the result stays held
//   and one more request waits in the input register; then tready drops.

module arcade_io_and_sound_latch_unit
  import arcio_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration: 3P/4P switch level
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  // Request channel
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [23:0] address, [39:24] data, [40] eeprom_bit_in, [43:41] pad_index, rest 0
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [2:0] op
  input  logic [OpW-1:0]      s_axis_tuser_i,
  // Result channel
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [15:0] read_data, [18:16] eeprom_lines, [19] sound_nmi,
  // [23:20] bg_palette_bank, [27:24] fg_palette_bank, [44:28] bg_scroll_x,
  // [60:45] bg_scroll_y, [77:61] fg_scroll_x, [94:78] fg_scroll_y,
  // [95] line_scroll_on, [97:96] sound_rom_bank, rest 0
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  req_t req_in;
  req_t req_held;
  res_t res_next;
  res_t res_held;
  logic in_valid;
  logic out_valid;
  logic advance;
  logic accept;

  // Unpack the request
  always_comb begin
    req_in.op            = s_axis_tuser_i;
    req_in.address       = s_axis_tdata_i[23:0];
    req_in.data          = s_axis_tdata_i[39:24];
    req_in.eeprom_bit_in = s_axis_tdata_i[40];
    req_in.pad_index     = s_axis_tdata_i[43:41];
  end

  // Advance when the result register is free or being emptied
  assign advance         = ~out_valid | m_axis_tready_i;
  assign s_axis_tready_o = ~in_valid | advance;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  arcio_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .drain_i (advance),
    .req_i   (req_in),
    .valid_o (in_valid),
    .req_o   (req_held)
  );

  arcio_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (in_valid & advance),
    .req_i       (req_held),
    .res_o       (res_next)
  );

  arcio_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_valid & advance),
    .ready_i (m_axis_tready_i),
    .res_i   (res_next),
    .valid_o (out_valid),
    .res_o   (res_held)
  );

  assign m_axis_tvalid_o = out_valid;

  // Pack the result, highest field first, read_data in the lowest bits
  assign m_axis_tdata_o = {
    6'd0,
    res_held.sound_rom_bank,
    res_held.line_scroll_on,
    res_held.fg_scroll_y,
    res_held.fg_scroll_x,
    res_held.bg_scroll_y,
    res_held.bg_scroll_x,
    res_held.fg_palette_bank,
    res_held.bg_palette_bank,
    res_held.sound_nmi,
    res_held.eeprom_lines,
    res_held.read_data
  };

endmodule

### tb/tb_arcade_io_and_sound_latch_unit.sv
// Self-checking testbench for arcade_io_and_sound_latch_unit: a directed table, then
// random bus accesses in phases with switch writes, checked against a local bus predictor.
// Depends on arcio_pkg and the unit's top level only.
`timescale 1ns / 1ps

module tb_arcade_io_and_sound_latch_unit;
  import arcio_pkg::*;

  // Op codes that the package leaves unnamed
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  localparam logic [7:0]         PortChipFirst   = 8'h08;
  localparam logic [DataW-1:0]   StatusLatchFree = 16'h0080;
  localparam logic [ScrollW-1:0] FgScrollXOffset = 17'd3;
  localparam int                 PhaseItems      = 200;
  localparam int                 NumPhases       = 4;
  localparam int                 LongHold        = 80;
  localparam int                 CycleLimit      = 200000;

  // One row of the directed table; rd_typed marks a read value written out by hand
  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [AddrW-1:0]   address;
    logic [DataW-1:0]   data;
    logic               ebit;
    logic [PadIdxW-1:0] pad_index;
    logic               rd_typed;
    logic [DataW-1:0]   rd_value;
  } stim_row_t;

  localparam int NumRows = 26;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [OpW-1:0]      s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // Predictor state
  logic               sw_level;
  logic [2:0]         eeprom_q;
  logic [7:0]         latch_q;
  logic               pending_q;
  logic [3:0]         bg_bank_q;
  logic [3:0]         fg_bank_q;
  logic [ScrollW-1:0] scroll_q [4];
  logic               line_scroll_q;
  logic [1:0]         rom_bank_q;
  logic [DataW-1:0]   pad_q [NumPads];

  res_t results_due [$];
  res_t seen_res;
  res_t due_res;
  int   mismatches = 0;
  int   results_seen = 0;
  int   cycle_count = 0;
  int   hold_cycles = 0;
  bit   no_gaps = 1'b0;

  logic [AddrW-1:0] write_map [10] = '{AddrEeprom, AddrLatch, AddrBgBank, AddrFgBank,
                                       AddrBgScrollX, AddrBgScrollY, AddrFgScrollX,
                                       AddrFgScrollY, AddrLineScrl, AddrLatch};
  logic [AddrW-1:0] read_map [6] = '{AddrPad0, AddrPad1, AddrPad2, AddrPad3,
                                     AddrStatus, AddrPad5};

  stim_row_t directed_rows [NumRows] = '{
    // after reset: idle pads, status with switch high and no latch pending
    '{OpMainRead,   AddrPad0,      16'h0000, 1'b0, 3'd0, 1'b1, 16'hffff},
    '{OpMainRead,   AddrStatus,    16'h0000, 1'b0, 3'd0, 1'b1, 16'hffbf},
    '{OpMainRead,   AddrStatus,    16'h0000, 1'b1, 3'd0, 1'b1, 16'hffff},
    '{OpMainByteRd, AddrStatus,    16'h0000, 1'b0, 3'd0, 1'b1, 16'h00ff},
    '{OpMainByteRd, AddrPad0,      16'hffff, 1'b1, 3'd7, 1'b1, 16'h0000},
    '{OpMainRead,   24'hffffff,    16'hffff, 1'b1, 3'd7, 1'b1, 16'h0000},
    // EEPROM lines all high, then all low
    '{OpMainWrite,  AddrEeprom,    16'h3800, 1'b0, 3'd0, 1'b0, 16'h0000},
    '{OpMainWrite,  AddrEeprom,    16'hc7ff, 1'b0, 3'd0, 1'b0, 16'h0000},
    // latch keeps the low byte only; status then shows it pending
    '{OpMainWrite,  AddrLatch,     16'habcd, 1'b0, 3'd0, 1'b0, 16'h0000},
    '{OpMainRead,   AddrStatus,    16'h0000, 1'b0, 3'd0, 1'b0, 16'h0000},
    '{OpSoundRead,  24'hffff04,    16'h0000, 1'b0, 3'd0, 1'b0, 16'h0000},
    '{OpSoundWrite, 24'h000104,    16'h0000, 1'b0, 3'd0, 1'b0, 16'h0000},
    '{OpSoundWrite, 24'h000000,    16'hffff, 1'b0, 3'd0, 1'b0, 16'h0000},
    // sound chip ports do nothing
    '{OpSoundWrite, 24'h000008,    16'h0002, 1'b0, 3'd0, 1'b0, 16'h0000},
    '{OpSoundRead,  24'hff000b,    16'h0000, 1'b1, 3'd0, 1'b1, 16'h0000},
    '{OpMainWrite,  AddrBgBank,    16'hf000, 1'b0, 3'd0, 1'b0, 16'h0000},
    '{OpMainWrite,  AddrFgBank,    16'h0fff, 1'b0, 3'd0, 1'b0, 16'h0000},
    '{OpMainWrite,  AddrBgScrollX, 16'hffff, 1'b0, 3'd0, 1'b0, 16'h0000},
    // foreground x scroll of zero wraps negative
    '{OpMainWrite,  AddrFgScrollX, 16'h0000, 1'b0, 3'd0, 1'b0, 16'h0000},
    '{OpMainWrite,  AddrFgScrollY, 16'hffff, 1'b0, 3'd0, 1'b0, 16'h0000},
    '{OpMainWrite,  AddrLineScrl,  16'h0000, 1'b0, 3'd0, 1'b0, 16'h0000},
    '{OpMainWrite,  AddrLineScrl,  16'h0200, 1'b0, 3'd0, 1'b0, 16'h0000},
    // pad loads: status word, index out of range ignored
    '{OpPadLoad,    24'h000000,    16'h0000, 1'b0, 3'd4, 1'b0, 16'h0000},
    '{OpPadLoad,    24'h000000,    16'h1234, 1'b0, 3'd7, 1'b0, 16'h0000},
    '{OpSpare6,     AddrStatus,    16'hffff, 1'b1, 3'd5, 1'b1, 16'h0000},
    '{OpSpare7,     AddrLatch,     16'hffff, 1'b1, 3'd5, 1'b1, 16'h0000}
  };

  arcade_io_and_sound_latch_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predict one bus access: update the local registers and build its result
  task automatic model_bus_access(input logic [OpW-1:0] op, input logic [AddrW-1:0] addr,
                                  input logic [DataW-1:0] data, input logic ebit,
                                  input logic [PadIdxW-1:0] pidx, output res_t r);
    logic [DataW-1:0] rd;
    logic             nmi;
    rd  = '0;
    nmi = 1'b0;
    case (op)
      OpMainWrite: begin
        case (addr)
          AddrEeprom:    eeprom_q = {data[13], data[12], data[11]};
          AddrLatch: begin
            latch_q   = data[7:0];
            pending_q = 1'b1;
            nmi       = 1'b1;
          end
          AddrBgBank:    bg_bank_q = data[15:12];
          AddrFgBank:    fg_bank_q = data[15:12];
          AddrBgScrollX: scroll_q[0] = {1'b0, data} + 17'd1;
          AddrBgScrollY: scroll_q[1] = {1'b0, data};
          AddrFgScrollX: scroll_q[2] = {1'b0, data} - FgScrollXOffset;
          AddrFgScrollY: scroll_q[3] = {1'b0, data} + 17'd1;
          AddrLineScrl:  line_scroll_q = ~data[9];
          default: ;
        endcase
      end
      OpMainRead: begin
        case (addr)
          AddrPad0: rd = pad_q[0];
          AddrPad1: rd = pad_q[1];
          AddrPad2: rd = pad_q[2];
          AddrPad3: rd = pad_q[3];
          AddrPad5: rd = pad_q[5];
          AddrStatus: begin
            rd = (pad_q[4] & StatusPadMask) | (DataW'(sw_level) << 4) | (DataW'(ebit) << 6);
            if (!pending_q) rd = rd | StatusLatchFree;
          end
          default: ;
        endcase
      end
      OpMainByteRd: if (addr == AddrStatus) rd = ByteReadValue;
      OpSoundWrite: begin
        if (addr[7:0] == PortBank) rom_bank_q = data[1:0];
        else if (addr[7:0] == PortLatch) pending_q = 1'b0;
      end
      OpSoundRead: if (addr[7:0] == PortLatch) rd = {8'h00, latch_q};
      OpPadLoad: if (pidx < PadIdxW'(NumPads)) pad_q[pidx] = data;
      default: ;
    endcase
    r.read_data       = rd;
    r.eeprom_lines    = eeprom_q;
    r.sound_nmi       = nmi;
    r.bg_palette_bank = bg_bank_q;
    r.fg_palette_bank = fg_bank_q;
    r.bg_scroll_x     = scroll_q[0];
    r.bg_scroll_y     = scroll_q[1][DataW-1:0];
    r.fg_scroll_x     = scroll_q[2];
    r.fg_scroll_y     = scroll_q[3];
    r.line_scroll_on  = line_scroll_q;
    r.sound_rom_bank  = rom_bank_q;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, name, got,
                                want));
  endtask

  // Offer one request after a random gap unless no_gaps is set, wait for it to be taken, then predict it.
  // Entered and left at a falling edge; tvalid stays high on exit.
  task automatic send_access(input logic [OpW-1:0] op, input logic [AddrW-1:0] addr,
                             input logic [DataW-1:0] data, input logic ebit,
                             input logic [PadIdxW-1:0] pidx, input logic rd_typed,
                             input logic [DataW-1:0] rd_value);
    int   gap;
    res_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  = {4'b0000, pidx, ebit, data, addr};
    s_axis_tuser_i  = op;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    model_bus_access(op, addr, data, ebit, pidx, r);
    if (rd_typed) r.read_data = rd_value;
    results_due.push_back(r);
    @(negedge clk_i);
  endtask

  // Stop offering and hold until every result is back and the pipe is empty
  task automatic drain_results();
    s_axis_tvalid_i = 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_switch(input logic level);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = level;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sw_level    = level;
    @(negedge clk_i);
  endtask

  // Draw one access, mostly on mapped addresses and ports
  task automatic pick_access(output logic [OpW-1:0] op, output logic [AddrW-1:0] addr,
                             output logic [DataW-1:0] data, output logic ebit,
                             output logic [PadIdxW-1:0] pidx);
    int          sel;
    logic [31:0] rnd;
    logic [7:0]  port;
    sel = $urandom_range(0, 99);
    rnd = $urandom();
    if (sel < 30)      op = OpMainWrite;
    else if (sel < 50) op = OpMainRead;
    else if (sel < 57) op = OpMainByteRd;
    else if (sel < 70) op = OpSoundWrite;
    else if (sel < 81) op = OpSoundRead;
    else if (sel < 95) op = OpPadLoad;
    else               op = ($urandom_range(0, 1) != 0) ? OpSpare7 : OpSpare6;
    addr = rnd[AddrW-1:0];
    if ($urandom_range(0, 99) < 85) begin
      case (op)
        OpMainWrite:  addr = write_map[$urandom_range(0, 9)];
        OpMainRead:   addr = read_map[$urandom_range(0, 5)];
        OpMainByteRd: addr = ($urandom_range(0, 1) != 0) ? AddrStatus : read_map[0];
        OpSoundWrite, OpSoundRead: begin
          case ($urandom_range(0, 2))
            0:       port = PortBank;
            1:       port = PortLatch;
            default: port = PortChipFirst + 8'($urandom_range(0, 3));
          endcase
          addr[7:0] = port;
        end
        default: ;
      endcase
    end
    rnd = $urandom();
    sel = $urandom_range(0, 99);
    if (sel < 8)       data = '0;
    else if (sel < 16) data = '1;
    else               data = rnd[DataW-1:0];
    ebit = rnd[16];
    pidx = 3'($urandom_range(0, 7));
  endtask

  // Receiver: random stall per result, or one long hold when asked
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Compare every taken result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none predicted", results_seen));
      end else begin
        due_res                  = results_due.pop_front();
        seen_res.read_data       = m_axis_tdata_o[15:0];
        seen_res.eeprom_lines    = m_axis_tdata_o[18:16];
        seen_res.sound_nmi       = m_axis_tdata_o[19];
        seen_res.bg_palette_bank = m_axis_tdata_o[23:20];
        seen_res.fg_palette_bank = m_axis_tdata_o[27:24];
        seen_res.bg_scroll_x     = m_axis_tdata_o[44:28];
        seen_res.bg_scroll_y     = m_axis_tdata_o[60:45];
        seen_res.fg_scroll_x     = m_axis_tdata_o[77:61];
        seen_res.fg_scroll_y     = m_axis_tdata_o[94:78];
        seen_res.line_scroll_on  = m_axis_tdata_o[95];
        seen_res.sound_rom_bank  = m_axis_tdata_o[97:96];
        check_field("read_data", 32'(seen_res.read_data), 32'(due_res.read_data));
        check_field("eeprom_lines", 32'(seen_res.eeprom_lines),
                    32'(due_res.eeprom_lines));
        check_field("sound_nmi", 32'(seen_res.sound_nmi), 32'(due_res.sound_nmi));
        check_field("bg_palette_bank", 32'(seen_res.bg_palette_bank),
                    32'(due_res.bg_palette_bank));
        check_field("fg_palette_bank", 32'(seen_res.fg_palette_bank),
                    32'(due_res.fg_palette_bank));
        check_field("bg_scroll_x", 32'(seen_res.bg_scroll_x), 32'(due_res.bg_scroll_x));
        check_field("bg_scroll_y", 32'(seen_res.bg_scroll_y), 32'(due_res.bg_scroll_y));
        check_field("fg_scroll_x", 32'(seen_res.fg_scroll_x), 32'(due_res.fg_scroll_x));
        check_field("fg_scroll_y", 32'(seen_res.fg_scroll_y), 32'(due_res.fg_scroll_y));
        check_field("line_scroll_on", 32'(seen_res.line_scroll_on),
                    32'(due_res.line_scroll_on));
        check_field("sound_rom_bank", 32'(seen_res.sound_rom_bank),
                    32'(due_res.sound_rom_bank));
      end
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_arcade_io_and_sound_latch_unit NOT OK");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases with switch writes
  initial begin
    logic [OpW-1:0]     op;
    logic [AddrW-1:0]   addr;
    logic [DataW-1:0]   data;
    logic               ebit;
    logic [PadIdxW-1:0] pidx;
    sw_level      = 1'b1;
    eeprom_q      = '0;
    latch_q       = '0;
    pending_q     = 1'b0;
    bg_bank_q     = '0;
    fg_bank_q     = '0;
    line_scroll_q = 1'b0;
    rom_bank_q    = '0;
    for (int k = 0; k < 4; k++) scroll_q[k] = '0;
    for (int k = 0; k < NumPads; k++) pad_q[k] = PadIdle;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < NumRows; k++)
      send_access(directed_rows[k].op, directed_rows[k].address, directed_rows[k].data,
                  directed_rows[k].ebit, directed_rows[k].pad_index,
                  directed_rows[k].rd_typed, directed_rows[k].rd_value);
    drain_results();

    for (int p = 0; p < NumPhases; p++) begin
      write_switch(p[0] ? 1'b1 : 1'b0);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 1 && i == 50) hold_cycles = LongHold;
        no_gaps = (p == 2 && i < 100);
        pick_access(op, addr, data, ebit, pidx);
        send_access(op, addr, data, ebit, pidx, 1'b0, '0);
      end
      no_gaps = 1'b0;
      drain_results();
    end

    repeat (8) @(negedge clk_i);
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", results_due.size()));
    if (mismatches == 0) begin
      $display("tb_arcade_io_and_sound_latch_unit OK");
    end else begin
      $display("tb_arcade_io_and_sound_latch_unit NOT OK");
    end
    $finish;
  end

endmodule

### files.f
design/arcio_pkg.sv
design/arcio_in_stage.sv
design/arcio_core.sv
design/arcio_out_stage.sv
design/arcade_io_and_sound_latch_unit.sv
tb/tb_arcade_io_and_sound_latch_unit.sv
